// File: rtl/core/assert_macros.svh
// assertion helpers for the rtl, clocked on clk_i with rst_ni low as reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TKR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define TKR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define TKR_ASSERT(lbl, prop, msg)

`define TKR_NEVER(lbl, cond, msg)

`endif

`endif

// File: rtl/core/tkr_pkg.sv
// ----------------------------------------------------------------------------
// tkr_pkg
// types, codes and defaults of the tap/hold key resolver
// ----------------------------------------------------------------------------
package tkr_pkg;

  localparam int DEF_ENTRIES    = 64;
  localparam int DEF_ROW_STRIDE = 16;
  localparam int MAX_RESULTS    = 64;
  localparam int CNT_W          = $clog2(MAX_RESULTS);
  localparam int CFG_IDX_W      = 3;

  localparam logic [1:0] MODE_ARM     = 2'd0;
  localparam logic [1:0] MODE_PRESS   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;
  localparam logic [1:0] MODE_TICK    = 2'd3;

  localparam logic [1:0] KIND_BASIC  = 2'd0;
  localparam logic [1:0] KIND_MOD    = 2'd1;
  localparam logic [1:0] KIND_LAYER  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_POLICY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERMISSIVE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPPING_TERM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_TAPHOLD = 3'd4;

  localparam logic [15:0] RST_TAPPING_TERM = 16'd200;
  localparam logic [15:0] RST_TYPE_MASK    = 16'hF000;
  localparam logic [15:0] RST_TYPE_TAPHOLD = 16'h7000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] keycode;
    logic [31:0] now_ms;
  } tkr_in_t;

  typedef struct packed {
    logic [1:0] action_kind;
    logic [7:0] action_value;
    logic       action_pressed;
    logic       accepted;
    logic       last;
  } tkr_out_t;

  typedef enum logic [1:0] {
    PLAN_NONE,
    PLAN_HOLD,
    PLAN_TAP,
    PLAN_HOLD_REL
  } plan_e;

  typedef enum logic [2:0] {
    EMIT_HOLD_PRESS,
    EMIT_HOLD_REL,
    EMIT_TAP_PRESS,
    EMIT_TAP_REL,
    EMIT_STATUS
  } emit_e;

  typedef struct packed {
    logic  load;
    logic  arm;
    logic  rd;
    logic  commit;
    logic  idx_inc;
    logic  emit;
    emit_e emit_code;
  } tkr_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    plan_e      plan;
    logic       idx_last;
    logic       out_free;
  } tkr_sts_t;

endpackage

// File: rtl/core/tkr_ctrl.sv
// ----------------------------------------------------------------------------
// tkr_ctrl
// sequencer: arm, release lookup and the walk over all key records
// ----------------------------------------------------------------------------
module tkr_ctrl import tkr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_mode_i,
  output logic       in_stall_o,
  input  tkr_sts_t   sts_i,
  output tkr_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARM,
    S_READ,
    S_EVAL,
    S_HOLD,
    S_TAPP,
    S_TAPR,
    S_HREL,
    S_STATUS
  } state_e;

  state_e state_q, state_d;
  logic   done_entry;

  // release handles one record, press and tick walk all of them
  assign done_entry = (sts_i.mode == MODE_RELEASE) || sts_i.idx_last;

  always_comb begin
    cmd_o   = '0;
    cmd_o.emit_code = EMIT_STATUS;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = (in_mode_i == MODE_ARM) ? S_ARM : S_READ;
        end
      end
      S_ARM: begin
        cmd_o.arm = 1'b1;
        state_d = S_STATUS;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.commit = 1'b1;
        case (sts_i.plan)
          PLAN_HOLD:     state_d = S_HOLD;
          PLAN_TAP:      state_d = S_TAPP;
          PLAN_HOLD_REL: state_d = S_HREL;
          default: begin
            if (done_entry) begin
              state_d = S_STATUS;
            end else begin
              cmd_o.idx_inc = 1'b1;
              state_d = S_READ;
            end
          end
        endcase
      end
      S_HOLD, S_TAPR, S_HREL: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          case (state_q)
            S_HOLD:  cmd_o.emit_code = EMIT_HOLD_PRESS;
            S_TAPR:  cmd_o.emit_code = EMIT_TAP_REL;
            default: cmd_o.emit_code = EMIT_HOLD_REL;
          endcase
          if (done_entry) begin
            state_d = S_STATUS;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_TAPP: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_code = EMIT_TAP_PRESS;
          state_d = S_TAPR;
        end
      end
      S_STATUS: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_code = EMIT_STATUS;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// File: rtl/core/tkr_dp.sv
// ----------------------------------------------------------------------------
// tkr_dp
// key record store, configuration registers, decision logic and result register
// ----------------------------------------------------------------------------
module tkr_dp import tkr_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int ROW_STRIDE = DEF_ROW_STRIDE
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tkr_in_t              in_data_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output tkr_out_t             out_data_o,
  input  tkr_cmd_t             cmd_i,
  output tkr_sts_t             sts_o
);

  localparam int IDX_W = $clog2(ENTRIES);

  typedef struct packed {
    logic        is_layer;
    logic [3:0]  hold_val;
    logic [7:0]  tap_code;
    logic [15:0] term;
    logic [31:0] t_down;
  } rec_t;

  // configuration
  logic        hold_policy_q, permissive_q;
  logic [15:0] term_q, type_mask_q, type_taphold_q;

  // current item
  logic [1:0]       mode_q;
  logic [IDX_W-1:0] slot_q;
  logic [15:0]      kc_q;
  logic [31:0]      now_q;
  logic             acc_q;
  logic [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0] cnt_q;

  // per-key flags, reset clears them; payload lives in the memory
  logic [ENTRIES-1:0] active_q, decided_q, intr_q, hold_q;
  rec_t               mem [ENTRIES];
  rec_t               rdata_q;

  logic             out_valid_q;
  tkr_out_t         out_q, res;

  logic [15:0]      lin;
  logic [IDX_W-1:0] slot_d, cur;
  logic             walk, match, open, cond_press, cond_tick;
  logic [31:0]      dt;
  logic             early;
  plan_e            plan;
  rec_t             wrec;

  assign lin = 16'(in_data_i.row) * 16'(ROW_STRIDE) + 16'(in_data_i.col);
  assign slot_d = (lin < 16'(ENTRIES)) ? lin[IDX_W-1:0] : IDX_W'(ENTRIES - 1);

  assign walk  = (mode_q == MODE_PRESS) || (mode_q == MODE_TICK);
  assign cur   = walk ? idx_q : slot_q;
  assign match = ((kc_q & type_mask_q) == type_taphold_q);
  assign open  = active_q[cur] && !decided_q[cur];
  assign dt    = now_q - rdata_q.t_down;
  assign early = (dt < {16'd0, rdata_q.term});

  assign cond_press = open && (idx_q != slot_q);
  assign cond_tick  = open && !early && (cnt_q != CNT_W'(MAX_RESULTS - 1));

  always_comb begin
    plan = PLAN_NONE;
    case (mode_q)
      MODE_PRESS: begin
        if (cond_press && !hold_policy_q) plan = PLAN_HOLD;
      end
      MODE_TICK: begin
        if (cond_tick) plan = PLAN_HOLD;
      end
      MODE_RELEASE: begin
        if (open) begin
          if (hold_policy_q && permissive_q && intr_q[cur] && early) plan = PLAN_HOLD;
          else plan = PLAN_TAP;
        end else if (active_q[cur] && hold_q[cur]) begin
          plan = PLAN_HOLD_REL;
        end
      end
      default: plan = PLAN_NONE;
    endcase
  end

  assign wrec.is_layer = !kc_q[11];
  assign wrec.hold_val = kc_q[11:8];
  assign wrec.tap_code = kc_q[7:0];
  assign wrec.term     = term_q;
  assign wrec.t_down   = now_q;

  always_comb begin
    res = '0;
    case (cmd_i.emit_code)
      EMIT_HOLD_PRESS, EMIT_HOLD_REL: begin
        res.action_kind    = rdata_q.is_layer ? KIND_LAYER : KIND_MOD;
        res.action_value   = {4'd0, rdata_q.hold_val};
        res.action_pressed = (cmd_i.emit_code == EMIT_HOLD_PRESS);
      end
      EMIT_TAP_PRESS, EMIT_TAP_REL: begin
        res.action_kind    = KIND_BASIC;
        res.action_value   = rdata_q.tap_code;
        res.action_pressed = (cmd_i.emit_code == EMIT_TAP_PRESS);
      end
      default: begin
        res.action_kind = KIND_STATUS;
        res.accepted    = acc_q;
        res.last        = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.arm && match) begin
      mem[slot_q] <= wrec;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[cur];
    end
    if (cmd_i.load) begin
      mode_q <= in_data_i.mode;
      slot_q <= slot_d;
      kc_q   <= in_data_i.keycode;
      now_q  <= in_data_i.now_ms;
    end
    if (cmd_i.emit) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_policy_q  <= 1'b0;
      permissive_q   <= 1'b0;
      term_q         <= RST_TAPPING_TERM;
      type_mask_q    <= RST_TYPE_MASK;
      type_taphold_q <= RST_TYPE_TAPHOLD;
      active_q       <= '0;
      decided_q      <= '0;
      intr_q         <= '0;
      hold_q         <= '0;
      acc_q          <= 1'b0;
      idx_q          <= '0;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_HOLD_POLICY:  hold_policy_q  <= cfg_data_i[0];
          CFG_PERMISSIVE:   permissive_q   <= cfg_data_i[0];
          CFG_TAPPING_TERM: term_q         <= cfg_data_i;
          CFG_TYPE_MASK:    type_mask_q    <= cfg_data_i;
          CFG_TYPE_TAPHOLD: type_taphold_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        acc_q <= 1'b0;
        idx_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.arm && match) begin
        acc_q             <= 1'b1;
        active_q[slot_q]  <= 1'b1;
        decided_q[slot_q] <= 1'b0;
        intr_q[slot_q]    <= 1'b0;
        hold_q[slot_q]    <= 1'b0;
      end
      if (cmd_i.commit) begin
        case (mode_q)
          MODE_RELEASE: begin
            if (active_q[cur]) begin
              acc_q         <= 1'b1;
              active_q[cur] <= 1'b0;
            end
          end
          MODE_PRESS: begin
            if (cond_press) begin
              intr_q[cur] <= 1'b1;
              if (!hold_policy_q) begin
                decided_q[cur] <= 1'b1;
                hold_q[cur]    <= 1'b1;
              end
            end
          end
          MODE_TICK: begin
            if (cond_tick) begin
              decided_q[cur] <= 1'b1;
              hold_q[cur]    <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.emit) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.mode     = mode_q;
  assign sts_o.plan     = plan;
  assign sts_o.idx_last = (idx_q == IDX_W'(ENTRIES - 1));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/tap_hold_key_resolver.sv
// ----------------------------------------------------------------------------
// tap_hold_key_resolver
// mod-tap / layer-tap resolver; slot row*ROW_STRIDE+col, clamped to the last, holds the record of a key
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  tkr_in_t (mode, row, col, keycode, now_ms)
//  out      output     out_valid/stall    tkr_out_t (action fields, accepted, last)
//  cfg      input      cfg_valid/ready    cfg_index, cfg_data (always ready)
//
//  arm runs accept, arm and status; release runs accept, memory read, decide,
//  each action result and status; press and tick walk every record (memory
//  read, then decide, then a hold result if one is emitted) between accept and status
//  output stalls hold the sequencer in place; in_stall is high while busy
//  reset clears all record flags at once, no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tap_hold_key_resolver import tkr_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int ROW_STRIDE = DEF_ROW_STRIDE
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tkr_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tkr_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  tkr_cmd_t cmd;
  tkr_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tkr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tkr_dp #(
    .ENTRIES    (ENTRIES),
    .ROW_STRIDE (ROW_STRIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  `TKR_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "busy")
  `TKR_NEVER(a_emit_into_full, cmd.emit && !sts.out_free, "result over a waiting one")
  `TKR_ASSERT(a_idle_after_status, $fell(in_stall_o) |-> $past(cmd.emit), "no status")

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// tap/hold key resolver: a queue-fed driver offers arm, press, release and
// tick transactions under several idle/stall mixes, a monitor compares every
// result against a behavioral predictor of the key record table
// ----------------------------------------------------------------------------
module testbench;
  import tkr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef struct {
    logic        active;
    logic        decided;
    logic        released;
    logic        interrupted;
    logic        is_hold;
    logic        is_layer;
    logic [31:0] t_down;
    logic [15:0] term;
    logic [7:0]  tap_code;
    logic [7:0]  hold_val;
  } key_rec_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  tkr_in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  tkr_out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0] cfg_data_i;

  tap_hold_key_resolver u_dut (.*);

  key_rec_t keys [DEF_ENTRIES];
  logic        pol_interrupt_n;
  logic        permissive;
  logic [15:0] term_ms;
  logic [15:0] mask;
  logic [15:0] taphold_val;

  tkr_in_t  pending_items[$];
  tkr_out_t expected_actions[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  logic [31:0] clock_ms = 0;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int key_slot(logic [7:0] row, logic [7:0] col);
    int idx;
    idx = int'(row) * DEF_ROW_STRIDE + int'(col);
    return idx < DEF_ENTRIES ? idx : DEF_ENTRIES - 1;
  endfunction

  function automatic tkr_out_t mk(logic [1:0] k, logic [7:0] v, logic p, logic a, logic l);
    tkr_out_t o;
    o.action_kind = k; o.action_value = v; o.action_pressed = p;
    o.accepted = a; o.last = l;
    return o;
  endfunction

  function automatic void push_hold(int i, logic pressed);
    expected_actions.push_back(mk(keys[i].is_layer ? KIND_LAYER : KIND_MOD,
                                  keys[i].hold_val, pressed, 1'b0, 1'b0));
  endfunction

  function automatic int hold_now(int i);
    if (keys[i].decided) return 0;
    keys[i].decided = 1; keys[i].is_hold = 1;
    push_hold(i, 1'b1);
    return 1;
  endfunction

  function automatic void resolve_item(tkr_in_t it);
    int s, n;
    logic acc;
    logic [31:0] dt;
    acc = 0; n = 0;
    s = key_slot(it.row, it.col);
    case (it.mode)
      MODE_ARM: begin
        if ((it.keycode & mask) == taphold_val) begin
          keys[s] = '{default: '0};
          keys[s].active = 1;
          keys[s].t_down = it.now_ms;
          keys[s].term = term_ms;
          keys[s].tap_code = it.keycode[7:0];
          keys[s].hold_val = {4'd0, it.keycode[11:8]};
          keys[s].is_layer = !it.keycode[11];
          acc = 1;
        end
      end
      MODE_PRESS: begin
        for (int i = 0; i < DEF_ENTRIES; i++) begin
          if (i != s && keys[i].active && !keys[i].decided && !keys[i].released) begin
            keys[i].interrupted = 1;
            if (!pol_interrupt_n) n += hold_now(i);
          end
        end
      end
      MODE_RELEASE: begin
        if (keys[s].active) begin
          keys[s].released = 1;
          if (!keys[s].decided) begin
            dt = it.now_ms - keys[s].t_down;
            if (pol_interrupt_n && permissive && keys[s].interrupted && dt < keys[s].term)
              n += hold_now(s);
            else begin
              keys[s].decided = 1; keys[s].is_hold = 0;
              expected_actions.push_back(mk(KIND_BASIC, keys[s].tap_code, 1'b1, 1'b0, 1'b0));
              expected_actions.push_back(mk(KIND_BASIC, keys[s].tap_code, 1'b0, 1'b0, 1'b0));
            end
          end else if (keys[s].is_hold) begin
            push_hold(s, 1'b0);
          end
          keys[s].active = 0;
          acc = 1;
        end
      end
      default: begin
        for (int i = 0; i < DEF_ENTRIES && n < MAX_RESULTS - 1; i++) begin
          if (keys[i].active && !keys[i].decided && !keys[i].released &&
              (it.now_ms - keys[i].t_down) >= 32'(keys[i].term))
            n += hold_now(i);
        end
      end
    endcase
    expected_actions.push_back(mk(KIND_STATUS, 8'd0, 1'b0, acc, 1'b1));
  endfunction

  logic in_taken;
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      resolve_item(in_data_i);
      void'(pending_items.pop_front());
    end
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
    end else if (!in_valid_i || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1;
        in_data_i <= pending_items[0];
      end else begin
        in_valid_i <= 0;
      end
    end
  end

  // receiver, with a counted hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tkr_out_t exp_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_actions.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %p", $time, out_data_o);
      end else begin
        exp_o = expected_actions.pop_front();
        if (out_data_o !== exp_o) begin
          errors++;
          $display("%0t mismatch: expected %p actual %p", $time, exp_o, out_data_o);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_HOLD_POLICY:  pol_interrupt_n = val[0];
      CFG_PERMISSIVE:   permissive = val[0];
      CFG_TAPPING_TERM: term_ms = val;
      CFG_TYPE_MASK:    mask = val;
      CFG_TYPE_TAPHOLD: taphold_val = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || expected_actions.size() != 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic tkr_in_t item(logic [1:0] m, logic [7:0] r, logic [7:0] c,
                                   logic [15:0] kc, logic [31:0] t);
    tkr_in_t it;
    it.mode = m; it.row = r; it.col = c; it.keycode = kc; it.now_ms = t;
    return it;
  endfunction

  // mostly tap-hold keycodes; rows and cols mostly small so slots stay in range
  function automatic tkr_in_t rand_item();
    logic [7:0] r, c;
    logic [15:0] kc;
    int pick;
    pick = $urandom_range(99);
    r = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    c = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
    kc = ($urandom_range(4) == 0) ? 16'($urandom)
                                  : ((16'($urandom) & ~mask) | (taphold_val & mask));
    clock_ms = clock_ms + 32'($urandom_range(term_ms + 40));
    if ($urandom_range(19) == 0) clock_ms = 32'($urandom);
    if (pick < 35) return item(MODE_ARM, r, c, kc, clock_ms);
    if (pick < 55) return item(MODE_PRESS, r, c, kc, clock_ms);
    if (pick < 80) return item(MODE_RELEASE, r, c, kc, clock_ms);
    return item(MODE_TICK, r, c, kc, clock_ms);
  endfunction

  task automatic random_phase(int count, int idle, int stall);
    send_idle_pct = idle; recv_stall_pct = stall;
    repeat (count) pending_items.push_back(rand_item());
    drain();
  endtask

  initial begin
    rst_ni = 0;
    in_valid_i = 0; in_data_i = '0; out_stall_i = 0;
    cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    in_taken = 0;
    for (int i = 0; i < DEF_ENTRIES; i++) keys[i] = '{default: '0};
    pol_interrupt_n = 0; permissive = 0;
    term_ms = RST_TAPPING_TERM; mask = RST_TYPE_MASK; taphold_val = RST_TYPE_TAPHOLD;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: tap, interrupt hold, tick hold, non tap-hold, inactive release
    pending_items.push_back(item(MODE_ARM, 0, 0, 16'h7A04, 32'd0));
    pending_items.push_back(item(MODE_RELEASE, 0, 0, 0, 32'd10));
    pending_items.push_back(item(MODE_RELEASE, 0, 0, 0, 32'd11));
    pending_items.push_back(item(MODE_ARM, 0, 1, 16'h7329, 32'd20));
    pending_items.push_back(item(MODE_PRESS, 0, 1, 0, 32'd21));
    pending_items.push_back(item(MODE_PRESS, 0, 2, 0, 32'd22));
    pending_items.push_back(item(MODE_RELEASE, 0, 1, 0, 32'd30));
    pending_items.push_back(item(MODE_ARM, 8'hFF, 8'hFF, 16'h7FFF, 32'hFFFF_FFF0));
    pending_items.push_back(item(MODE_TICK, 0, 0, 0, 32'hFFFF_FFFF));
    pending_items.push_back(item(MODE_TICK, 0, 0, 0, 32'd300));
    pending_items.push_back(item(MODE_RELEASE, 8'hFF, 8'hFF, 0, 32'd301));
    pending_items.push_back(item(MODE_ARM, 1, 2, 16'h0000, 32'd302));
    pending_items.push_back(item(MODE_ARM, 1, 2, 16'hFFFF, 32'd303));
    pending_items.push_back(item(MODE_RELEASE, 1, 2, 0, 32'd304));
    drain();

    // permissive policy, term changed while armed
    write_reg(CFG_HOLD_POLICY, 16'd1);
    write_reg(CFG_PERMISSIVE, 16'd1);
    pending_items.push_back(item(MODE_ARM, 0, 3, 16'h7812, 32'd1000));
    pending_items.push_back(item(MODE_ARM, 0, 4, 16'h7234, 32'd1000));
    drain();
    write_reg(CFG_TAPPING_TERM, 16'd5);
    pending_items.push_back(item(MODE_PRESS, 0, 3, 0, 32'd1001));
    pending_items.push_back(item(MODE_RELEASE, 0, 4, 0, 32'd1100));
    pending_items.push_back(item(MODE_TICK, 0, 0, 0, 32'd1100));
    pending_items.push_back(item(MODE_RELEASE, 0, 3, 0, 32'd1101));
    // fill the whole table, then a tick that overflows and one more tick
    for (int i = 0; i < DEF_ENTRIES; i++)
      pending_items.push_back(item(MODE_ARM, 8'(i / 16), 8'(i % 16), 16'h7900, 32'd2000));
    pending_items.push_back(item(MODE_TICK, 0, 0, 0, 32'd3000));
    pending_items.push_back(item(MODE_TICK, 0, 0, 0, 32'd3001));
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_off = 2000;
    random_phase(20, 0, 0);

    write_reg(CFG_HOLD_POLICY, 16'd0);
    write_reg(CFG_PERMISSIVE, 16'd0);
    write_reg(CFG_TAPPING_TERM, 16'd0);
    random_phase(25, 0, 0);
    write_reg(CFG_TAPPING_TERM, 16'hFFFF);
    random_phase(25, 87, 0);
    write_reg(CFG_HOLD_POLICY, 16'd1);
    write_reg(CFG_PERMISSIVE, 16'd1);
    write_reg(CFG_TAPPING_TERM, 16'd50);
    random_phase(25, 0, 87);
    write_reg(CFG_TYPE_MASK, 16'hFFFF);
    write_reg(CFG_TYPE_TAPHOLD, 16'hFFFF);
    random_phase(10, 30, 30);
    write_reg(CFG_TYPE_MASK, 16'h0000);
    write_reg(CFG_TYPE_TAPHOLD, 16'h0000);
    write_reg(CFG_IDX_UNUSED, 16'hFFFF);
    write_reg(CFG_PERMISSIVE, 16'd0);
    random_phase(15, 30, 30);

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/tkr_pkg.sv
rtl/core/tkr_ctrl.sv
rtl/core/tkr_dp.sv
rtl/core/tap_hold_key_resolver.sv
test/testbench.sv
